### hw/rtl/vri_pkg.sv
package vri_pkg;

  localparam int OBJECT_BYTES_DEF    = 256;
  localparam int NAMETABLE_BYTES_DEF = 1024;
  localparam int PATTERN_BYTES_DEF   = 4096;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_VBLANK = 3'd3;
  localparam logic [2:0] CMD_FRAME  = 3'd4;

  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;

  localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
  localparam logic [7:0]  PAL_MASK_GRAY = 8'h30;
  localparam logic [7:0]  PAL_MASK_FULL = 8'h3F;
  localparam logic [15:0] ADDR_STEP_ROW = 16'd32;
  localparam logic [15:0] ADDR_STEP_COL = 16'd1;

  typedef struct packed {
    logic capture;
    logic execute;
  } vri_cmd_t;

endpackage

### hw/rtl/vri_in_if.sv
interface vri_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, command, reg_index, write_data, input ready);
  modport sink (input valid, command, reg_index, write_data, output ready);
endinterface

### hw/rtl/vri_out_if.sv
interface vri_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi_request;

  modport source (output valid, read_data, nmi_request, input ready);
  modport sink (input valid, read_data, nmi_request, output ready);
endinterface

### hw/rtl/vri_ctrl.sv
module vri_ctrl
  import vri_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output vri_cmd_t cmd
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.capture) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (cmd.execute) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cmd.execute) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("executed item produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && out_valid_r && !out_ready |=> (state_r == ST_EXEC))
    else $error("item left execution while the result register was full");
`endif

endmodule

### hw/rtl/vri_datapath.sv
module vri_datapath
  import vri_pkg::*;
#(
  parameter int OBJECT_BYTES    = OBJECT_BYTES_DEF,
  parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
  parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  vri_cmd_t   cmd,
  input  logic [2:0] in_command,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  output logic [7:0] out_read_data,
  output logic       out_nmi_request
);

  localparam int OBJ_AW = $clog2(OBJECT_BYTES);
  localparam int NT_AW  = $clog2(2 * NAMETABLE_BYTES);
  localparam int PAT_AW = $clog2(2 * PATTERN_BYTES);

  logic [2:0]  cmd_r, reg_r;
  logic [7:0]  wdata_r;
  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  obj_addr_r, obj_addr_nxt;
  logic        toggle_r, toggle_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic [15:0] tmp_addr_r, tmp_addr_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [7:0]  rd_data_r, rd_nxt;
  logic        nmi_r, nmi_nxt;

  logic [7:0] obj_mem [OBJECT_BYTES];
  logic [7:0] pat_mem [2 * PATTERN_BYTES];
  logic [7:0] nt_mem  [2 * NAMETABLE_BYTES];
  logic [7:0] pal_mem [32];
  logic [7:0] obj_q_r, pat_q_r, nt_q_r, pal_q_r;

  logic [13:0]       vaddr;
  logic              is_pat, is_pal, nt_on, nt_table;
  logic [NT_AW-1:0]  nt_idx;
  logic [4:0]        pal_idx;
  logic [7:0]        vval;
  logic              obj_we, pat_we, nt_we, pal_we, advance;

  assign vaddr    = cur_addr_r[13:0];
  assign is_pat   = !vaddr[13];
  assign is_pal   = (vaddr >= PALETTE_BASE);
  assign nt_on    = (mirror_r == MIRROR_HORIZONTAL) || (mirror_r == MIRROR_VERTICAL);
  assign nt_table = (mirror_r == MIRROR_HORIZONTAL) ? vaddr[11] : vaddr[10];
  assign nt_idx   = {nt_table, vaddr[NT_AW-2:0]};
  assign pal_idx  = ((vaddr[1:0] == 2'b00) && vaddr[4]) ? {1'b0, vaddr[3:0]} : vaddr[4:0];

  always_comb begin
    priority if (is_pat) begin
      vval = pat_q_r;
    end else if (!is_pal) begin
      vval = nt_on ? nt_q_r : 8'd0;
    end else begin
      vval = pal_q_r & (mask_r[0] ? PAL_MASK_GRAY : PAL_MASK_FULL);
    end
  end

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    obj_addr_nxt = obj_addr_r;
    toggle_nxt   = toggle_r;
    fine_x_nxt   = fine_x_r;
    tmp_addr_nxt = tmp_addr_r;
    cur_addr_nxt = cur_addr_r;
    rbuf_nxt     = rbuf_r;
    rd_nxt       = 8'd0;
    nmi_nxt      = 1'b0;
    obj_we       = 1'b0;
    pat_we       = 1'b0;
    nt_we        = 1'b0;
    pal_we       = 1'b0;
    advance      = 1'b0;
    unique case (cmd_r)
      CMD_READ: begin
        unique case (reg_r)
          REG_STATUS: begin
            rd_nxt        = {status_r[7:5], rbuf_r[4:0]};
            status_nxt[7] = 1'b0;
            toggle_nxt    = 1'b0;
          end
          REG_OAM_DATA: rd_nxt = obj_q_r;
          REG_DATA: begin
            rd_nxt   = is_pal ? vval : rbuf_r;
            rbuf_nxt = vval;
            advance  = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        unique case (reg_r)
          REG_CONTROL: begin
            ctrl_nxt     = wdata_r;
            tmp_addr_nxt = {tmp_addr_r[15:12], wdata_r[1:0], tmp_addr_r[9:0]};
          end
          REG_MASK:     mask_nxt = wdata_r;
          REG_OAM_ADDR: obj_addr_nxt = wdata_r;
          REG_OAM_DATA: obj_we = 1'b1;
          REG_SCROLL: begin
            if (!toggle_r) begin
              fine_x_nxt   = wdata_r[2:0];
              tmp_addr_nxt = {tmp_addr_r[15:5], wdata_r[7:3]};
              toggle_nxt   = 1'b1;
            end else begin
              tmp_addr_nxt = {tmp_addr_r[15], wdata_r[2:0], tmp_addr_r[11:10],
                              wdata_r[7:3], tmp_addr_r[4:0]};
              toggle_nxt   = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!toggle_r) begin
              tmp_addr_nxt = {2'b00, wdata_r[5:0], tmp_addr_r[7:0]};
              toggle_nxt   = 1'b1;
            end else begin
              tmp_addr_nxt = {tmp_addr_r[15:8], wdata_r};
              cur_addr_nxt = {tmp_addr_r[15:8], wdata_r};
              toggle_nxt   = 1'b0;
            end
          end
          REG_DATA: begin
            pat_we  = is_pat;
            nt_we   = !is_pat && !is_pal && nt_on;
            pal_we  = is_pal;
            advance = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_PEEK: begin
        unique case (reg_r)
          REG_CONTROL: rd_nxt = ctrl_r;
          REG_MASK:    rd_nxt = mask_r;
          REG_STATUS:  rd_nxt = status_r;
          default: ;
        endcase
      end
      CMD_VBLANK: begin
        status_nxt[7] = 1'b1;
        nmi_nxt       = ctrl_r[7];
      end
      CMD_FRAME: status_nxt[7:5] = 3'b000;
      default: ;
    endcase
    if (advance) begin
      cur_addr_nxt = cur_addr_r + (ctrl_r[2] ? ADDR_STEP_ROW : ADDR_STEP_COL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= MIRROR_HORIZONTAL;
    end else if (cfg_wr_en) begin
      mirror_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      reg_r   <= in_reg_index;
      wdata_r <= in_write_data;
    end
    if (cmd.execute) begin
      rd_data_r <= rd_nxt;
      nmi_r     <= nmi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= 8'd0;
      mask_r     <= 8'd0;
      status_r   <= 8'd0;
      obj_addr_r <= 8'd0;
      toggle_r   <= 1'b0;
      fine_x_r   <= 3'd0;
      tmp_addr_r <= 16'd0;
      cur_addr_r <= 16'd0;
      rbuf_r     <= 8'd0;
    end else if (cmd.execute) begin
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      status_r   <= status_nxt;
      obj_addr_r <= obj_addr_nxt;
      toggle_r   <= toggle_nxt;
      fine_x_r   <= fine_x_nxt;
      tmp_addr_r <= tmp_addr_nxt;
      cur_addr_r <= cur_addr_nxt;
      rbuf_r     <= rbuf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && obj_we) obj_mem[obj_addr_r[OBJ_AW-1:0]] <= wdata_r;
    obj_q_r <= obj_mem[obj_addr_r[OBJ_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && pat_we) pat_mem[vaddr[PAT_AW-1:0]] <= wdata_r;
    pat_q_r <= pat_mem[vaddr[PAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && nt_we) nt_mem[nt_idx] <= wdata_r;
    nt_q_r <= nt_mem[nt_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && pal_we) pal_mem[pal_idx] <= wdata_r;
    pal_q_r <= pal_mem[pal_idx];
  end

  assign out_read_data   = rd_data_r;
  assign out_nmi_request = nmi_r;

`ifndef SYNTHESIS
  a_vblank_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (cmd_r == CMD_VBLANK) |=> status_r[7])
    else $error("vblank start did not set the status flag");

  a_status_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (cmd_r == CMD_READ) && (reg_r == REG_STATUS) |=> !status_r[7] && !toggle_r)
    else $error("status read did not clear vblank flag and write latch");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (cmd_r == CMD_FRAME) |=> (status_r[7:5] == 3'b000))
    else $error("frame start did not clear the status flags");
`endif

endmodule

### hw/rtl/video_register_interface.sv
// Channel   Direction  Payload                           Accepted when
// in_ch     in         command, reg_index, write_data    in_ch.valid && in_ch.ready
// out_ch    out        read_data, nmi_request            out_ch.valid && out_ch.ready
// cfg       in         cfg_wr_data (mirroring mode)      cfg_wr_en
//
// Each item is captured while the synchronous stores are read, and is executed after that.
// The memories are not cleared by reset and hold no valid bits.
// Reset clears the mode, state and registers, but not the captured item or the result data.
// A full result register holds the item in execution until out_ch is ready again.
module video_register_interface
  import vri_pkg::*;
#(
  parameter int OBJECT_BYTES    = OBJECT_BYTES_DEF,
  parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
  parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vri_in_if.sink     in_ch,
  vri_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  vri_cmd_t cmd;

  vri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  vri_datapath #(
    .OBJECT_BYTES    (OBJECT_BYTES),
    .NAMETABLE_BYTES (NAMETABLE_BYTES),
    .PATTERN_BYTES   (PATTERN_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_command      (in_ch.command),
    .in_reg_index    (in_ch.reg_index),
    .in_write_data   (in_ch.write_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_read_data   (out_ch.read_data),
    .out_nmi_request (out_ch.nmi_request)
  );

endmodule
